// ===== rtl/core/gfd_pkg.sv =====
// Package for the gaze fixation detector: constants, types and state codes.
// No dependencies.
package gfd_pkg;

  localparam int MAX_POINTS_DEFAULT = 65535;
  localparam int TIME_BITS_DEFAULT  = 48;
  localparam int CFG_BITS           = 32;
  localparam int CFG_INDEX_BITS     = 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_FIX_LIMIT = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SAC_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] REG_BREAK     = 2'd2;
  localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_TIME  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DIFF,
    ST_SQX,
    ST_SQY,
    ST_E6,
    ST_FIXB,
    ST_FSQ,
    ST_SACB,
    ST_SSQ,
    ST_BRK,
    ST_DECIDE,
    ST_DIVX,
    ST_DIVY,
    ST_EMIT,
    ST_UPDATE
  } state_t;

  // Operand request to the shared bit-serial multiplier.
  typedef struct packed {
    logic        start;
    logic [63:0] a;
    logic [63:0] b;
  } mul_req_t;

endpackage

// ===== rtl/core/gfd_serial_mul.sv =====
// Shift-and-add multiplier, one multiplier bit per cycle, 128-bit product.
// Depends on gfd_pkg.
module gfd_serial_mul (
  input  logic              clk,
  input  logic              rst,
  input  gfd_pkg::mul_req_t req,
  output logic              done,
  output logic [127:0]      product
);

  logic [127:0] acc;
  logic [127:0] mcand;
  logic [63:0]  mplier;
  logic         busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy   <= 1'b1;
        acc    <= '0;
        mcand  <= {64'd0, req.a};
        mplier <= req.b;
      end else if (busy) begin
        if (mplier[0]) begin
          acc <= acc + mcand;
        end
        mcand  <= mcand << 1;
        mplier <= mplier >> 1;
        if (mplier[63:1] == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    product = acc;
  end

endmodule

// ===== rtl/core/gfd_serial_div.sv =====
// Restoring signed divider, one quotient bit per cycle, truncating toward zero.
// No package dependency.
module gfd_serial_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] dividend,
  input  logic        [15:0] divisor,
  output logic               done,
  output logic signed [31:0] quotient
);

  logic [31:0] q;
  logic [31:0] rem;
  logic [15:0] dvs;
  logic [5:0]  cnt;
  logic        neg;
  logic        busy;
  logic [32:0] trial;

  always_comb begin
    trial = {rem[31:0], q[31]} - {17'd0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        neg  <= dividend[31];
        q    <= dividend[31] ? (32'd0 - dividend) : dividend;
        rem  <= '0;
        dvs  <= divisor;
        cnt  <= 6'd0;
      end else if (busy) begin
        if (!trial[32]) begin
          rem <= trial[31:0];
          q   <= {q[30:0], 1'b1};
        end else begin
          rem <= {rem[30:0], q[31]};
          q   <= {q[30:0], 1'b0};
        end
        cnt <= cnt + 6'd1;
        if (cnt == 6'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    quotient = neg ? (32'sd0 - $signed(q)) : $signed(q);
  end

endmodule

// ===== rtl/core/gaze_fixation_detector.sv =====
// Top level of the gaze fixation detector: control sequencer and group state.
// Depends on gfd_pkg, gfd_serial_mul and gfd_serial_div.
//
//   channel | direction | handshake        | payload
//   sample  | in        | sample_valid/stall | sample_time, pupils, gaze x/y
//   result  | out       | result_valid/stall | start, centroid, length, count
//   config  | in        | cfg_write        | cfg_index, cfg_data
//
// An item with a stored previous point keeps the block busy while eight products
// run in turn on the shared shift-and-add multiplier (one multiplier bit per
// cycle each); an emitted group adds two centroid divisions. The first valid
// item goes from DIFF to UPDATE; one with no valid eye is taken and dropped.
// Reset is synchronous and clears all control and group state.
// A finished result waits in the output register; a new item is taken only
// once it has gone.
module gaze_fixation_detector #(
  parameter int MAX_GROUP_POINTS = gfd_pkg::MAX_POINTS_DEFAULT,
  parameter int TIME_BITS        = gfd_pkg::TIME_BITS_DEFAULT
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_write,
  input  logic [gfd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  logic [gfd_pkg::CFG_BITS-1:0]        cfg_data,
  input  logic                                sample_valid,
  output logic                                sample_stall,
  input  logic [TIME_BITS-1:0]                sample_time,
  input  logic [15:0]                         left_pupil_size,
  input  logic signed [15:0]                  left_gaze_x,
  input  logic signed [15:0]                  left_gaze_y,
  input  logic [15:0]                         right_pupil_size,
  input  logic signed [15:0]                  right_gaze_x,
  input  logic signed [15:0]                  right_gaze_y,
  output logic                                result_valid,
  input  logic                                result_stall,
  output logic [47:0]                         fixation_start,
  output logic signed [15:0]                  centroid_x,
  output logic signed [15:0]                  centroid_y,
  output logic signed [47:0]                  fixation_length,
  output logic [15:0]                         point_total
);

  localparam logic [15:0] MAXP = 16'(MAX_GROUP_POINTS);

  logic [15:0] fix_limit, sac_limit, brk_dist;
  logic [31:0] min_time;

  gfd_pkg::state_t state, state_next;

  logic               have_prev, grp_open;
  logic signed [15:0] prev_x, prev_y, cur_x, cur_y;
  logic [TIME_BITS-1:0] prev_time, cur_time, diff, grp_start, grp_tsum;
  logic [15:0]        grp_pts;
  logic signed [31:0] sum_x, sum_y;
  logic signed [16:0] dx, dy;
  logic [63:0]        d2, d2e6;
  logic [31:0]        fbound, sbound;
  logic               fbig, sbig;

  logic               neg;
  logic [TIME_BITS-1:0] mag;

  gfd_pkg::mul_req_t mreq;
  logic              mdone;
  logic [127:0]      mprod;
  logic              dstart, ddone;
  logic signed [31:0] dquot, ddend;

  // Snapshot of the group taken at close time.
  logic [TIME_BITS-1:0] cl_start, cl_tsum;
  logic [15:0]        cl_pts;
  logic signed [31:0] cl_sx, cl_sy;
  logic signed [15:0] cx_hold;
  logic               mstarted;

  logic accept;
  logic lv, rv;
  logic signed [16:0] ax, ay;

  logic        fix, sac, brk_hit, close_now, emit_ok;
  logic [63:0] fsq, ssq, brk2;

  function automatic logic close_ok(input logic [15:0] pts,
                                    input logic [TIME_BITS-1:0] tsum,
                                    input logic [31:0] mt);
    logic signed [TIME_BITS:0] dur;
    dur = {tsum[TIME_BITS-1], tsum};
    close_ok = (pts != 16'd0) && (dur >= $signed({{(TIME_BITS-31){1'b0}}, mt}));
  endfunction

  assign accept = sample_valid && !sample_stall;
  assign sample_stall = (state != gfd_pkg::ST_IDLE) || result_valid;
  assign lv = left_pupil_size != 16'd0;
  assign rv = right_pupil_size != 16'd0;
  assign ax = 17'(left_gaze_x) + 17'(right_gaze_x);
  assign ay = 17'(left_gaze_y) + 17'(right_gaze_y);

  assign neg = diff[TIME_BITS-1];
  assign mag = neg ? (TIME_BITS'(0) - diff) : diff;

  gfd_serial_mul u_mul (
    .clk(clk), .rst(rst), .req(mreq), .done(mdone), .product(mprod)
  );

  gfd_serial_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .dividend(ddend),
    .divisor(cl_pts), .done(ddone), .quotient(dquot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      fix_limit <= 16'd100;
      sac_limit <= 16'd300;
      brk_dist  <= 16'd800;
      min_time  <= 32'd100000;
    end else if (cfg_write) begin
      case (cfg_index)
        gfd_pkg::REG_FIX_LIMIT: fix_limit <= cfg_data[15:0];
        gfd_pkg::REG_SAC_LIMIT: sac_limit <= cfg_data[15:0];
        gfd_pkg::REG_BREAK:     brk_dist  <= cfg_data[15:0];
        gfd_pkg::REG_MIN_TIME:  min_time  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gfd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // limit*mag fits 32 bits when not big, so its square fits 64 bits.
  always_comb begin
    fix       = neg || ((fix_limit != 16'd0) && !fbig && (d2e6 < fsq));
    sac       = !neg && (sac_limit == 16'd0 || !sbig) &&
                (d2e6 > ((sac_limit == 16'd0) ? 64'd0 : ssq));
    brk_hit   = d2 > brk2;
    close_now = grp_open && (fix ? brk_hit : sac);
    emit_ok   = close_now && close_ok(grp_pts, grp_tsum, min_time);
  end

  // Each multiply step starts the unit once, then waits for done.
  always_comb begin
    state_next = state;
    mreq       = '0;
    dstart     = 1'b0;
    ddend      = cl_sx;
    case (state)
      gfd_pkg::ST_IDLE: begin
        if (accept && (lv || rv)) begin
          state_next = gfd_pkg::ST_DIFF;
        end
      end
      gfd_pkg::ST_DIFF: begin
        state_next = have_prev ? gfd_pkg::ST_SQX : gfd_pkg::ST_UPDATE;
      end
      gfd_pkg::ST_SQX: begin
        mreq.start = !mstarted;
        mreq.a = 64'(dx[16] ? -dx : dx);
        mreq.b = 64'(dx[16] ? -dx : dx);
        if (mdone) state_next = gfd_pkg::ST_SQY;
      end
      gfd_pkg::ST_SQY: begin
        mreq.start = !mstarted;
        mreq.a = 64'(dy[16] ? -dy : dy);
        mreq.b = 64'(dy[16] ? -dy : dy);
        if (mdone) state_next = gfd_pkg::ST_E6;
      end
      gfd_pkg::ST_E6: begin
        mreq.start = !mstarted;
        mreq.a = d2;
        mreq.b = 64'd1000000;
        if (mdone) state_next = gfd_pkg::ST_FIXB;
      end
      gfd_pkg::ST_FIXB: begin
        mreq.start = !mstarted;
        mreq.a = 64'(mag);
        mreq.b = 64'(fix_limit);
        if (mdone) state_next = gfd_pkg::ST_FSQ;
      end
      gfd_pkg::ST_FSQ: begin
        mreq.start = !mstarted;
        mreq.a = 64'(fbound);
        mreq.b = 64'(fbound);
        if (mdone) state_next = gfd_pkg::ST_SACB;
      end
      gfd_pkg::ST_SACB: begin
        mreq.start = !mstarted;
        mreq.a = 64'(mag);
        mreq.b = 64'(sac_limit);
        if (mdone) state_next = gfd_pkg::ST_SSQ;
      end
      gfd_pkg::ST_SSQ: begin
        mreq.start = !mstarted;
        mreq.a = 64'(sbound);
        mreq.b = 64'(sbound);
        if (mdone) state_next = gfd_pkg::ST_BRK;
      end
      gfd_pkg::ST_BRK: begin
        mreq.start = !mstarted;
        mreq.a = 64'(brk_dist);
        mreq.b = 64'(brk_dist);
        if (mdone) state_next = gfd_pkg::ST_DECIDE;
      end
      gfd_pkg::ST_DECIDE: begin
        state_next = emit_ok ? gfd_pkg::ST_DIVX : gfd_pkg::ST_UPDATE;
      end
      gfd_pkg::ST_DIVX: begin
        dstart = !mstarted;
        ddend  = cl_sx;
        if (ddone) state_next = gfd_pkg::ST_DIVY;
      end
      gfd_pkg::ST_DIVY: begin
        dstart = !mstarted;
        ddend  = cl_sy;
        if (ddone) state_next = gfd_pkg::ST_EMIT;
      end
      gfd_pkg::ST_EMIT: begin
        state_next = gfd_pkg::ST_UPDATE;
      end
      gfd_pkg::ST_UPDATE: begin
        state_next = gfd_pkg::ST_IDLE;
      end
      default: state_next = gfd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mstarted  <= 1'b0;
      have_prev <= 1'b0;
      grp_open  <= 1'b0;
      prev_x    <= '0;
      prev_y    <= '0;
      prev_time <= '0;
      grp_pts   <= '0;
      sum_x     <= '0;
      sum_y     <= '0;
      grp_tsum  <= '0;
      grp_start <= '0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall) result_valid <= 1'b0;
      mstarted <= (state_next == state) && (state != gfd_pkg::ST_IDLE);
      case (state)
        gfd_pkg::ST_IDLE: begin
          if (accept) begin
            cur_time <= sample_time;
            if (lv && rv) begin
              cur_x <= ax[16:1];
              cur_y <= ay[16:1];
            end else if (lv) begin
              cur_x <= left_gaze_x;
              cur_y <= left_gaze_y;
            end else begin
              cur_x <= right_gaze_x;
              cur_y <= right_gaze_y;
            end
          end
        end
        gfd_pkg::ST_DIFF: begin
          dx   <= 17'(cur_x) - 17'(prev_x);
          dy   <= 17'(cur_y) - 17'(prev_y);
          diff <= cur_time - prev_time;
        end
        gfd_pkg::ST_SQX: if (mdone) d2 <= mprod[63:0];
        gfd_pkg::ST_SQY: if (mdone) d2 <= d2 + mprod[63:0];
        gfd_pkg::ST_E6:  if (mdone) d2e6 <= mprod[63:0];
        gfd_pkg::ST_FIXB: if (mdone) begin
          fbound <= mprod[31:0];
          fbig   <= (mprod[127:32] != '0);
        end
        gfd_pkg::ST_FSQ: if (mdone) fsq <= mprod[63:0];
        gfd_pkg::ST_SACB: if (mdone) begin
          sbound <= mprod[31:0];
          sbig   <= (mprod[127:32] != '0);
        end
        gfd_pkg::ST_SSQ: if (mdone) ssq <= mprod[63:0];
        gfd_pkg::ST_BRK: if (mdone) brk2 <= mprod[63:0];
        gfd_pkg::ST_DECIDE: begin
          if (close_now) begin
            cl_start <= grp_start; cl_tsum <= grp_tsum; cl_pts <= grp_pts;
            cl_sx <= sum_x; cl_sy <= sum_y;
          end
          if (fix) begin
            if (!grp_open || brk_hit) begin
              grp_start <= cur_time;
              grp_open  <= 1'b1;
            end
            if (grp_open && !brk_hit && grp_pts != 16'd0) begin
              grp_tsum <= grp_tsum + diff;
            end else begin
              grp_tsum <= '0;
            end
            if (!grp_open || brk_hit) begin
              grp_pts <= 16'd1;
              sum_x   <= 32'(cur_x);
              sum_y   <= 32'(cur_y);
            end else if (grp_pts < MAXP) begin
              grp_pts <= grp_pts + 16'd1;
              sum_x   <= sum_x + 32'(cur_x);
              sum_y   <= sum_y + 32'(cur_y);
            end
          end else if (sac) begin
            grp_open <= 1'b0;
          end
        end
        gfd_pkg::ST_DIVX: if (ddone) cx_hold <= dquot[15:0];
        gfd_pkg::ST_DIVY: if (ddone) begin
          centroid_x <= cx_hold;
          centroid_y <= dquot[15:0];
        end
        gfd_pkg::ST_EMIT: begin
          fixation_start  <= 48'(cl_start);
          fixation_length <= 48'(signed'(cl_tsum));
          point_total     <= cl_pts;
          result_valid    <= 1'b1;
        end
        gfd_pkg::ST_UPDATE: begin
          have_prev <= 1'b1;
          prev_x    <= cur_x;
          prev_y    <= cur_y;
          prev_time <= cur_time;
        end
        default: ;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    accept |-> state == gfd_pkg::ST_IDLE && !result_valid)
    else $error("item taken while busy");
  assert property (@(posedge clk) disable iff (rst)
    state == gfd_pkg::ST_EMIT |-> cl_pts != 16'd0)
    else $error("empty group emitted");
  assert property (@(posedge clk) disable iff (rst)
    grp_open |-> grp_pts != 16'd0 || state != gfd_pkg::ST_IDLE)
    else $error("open group without points");

endmodule
